/* sv/spq_pkg.sv */
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic              enq;
        logic              deq;
        logic              load;
        logic [STAT_W-1:0] status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

/* sv/spq_if.sv */
interface spq_req_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic signed [spq_pkg::VALUE_W-1:0] value_in;
    logic        [spq_pkg::PRIO_W-1:0]  priority_in;

    modport source (output valid, kind, value_in, priority_in, input ready);
    modport sink   (input valid, kind, value_in, priority_in, output ready);
endinterface

interface spq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic        [spq_pkg::STAT_W-1:0]  status;
    logic signed [spq_pkg::VALUE_W-1:0] value_out;
    logic        [spq_pkg::CNT_W-1:0]   occupancy;

    modport source (output valid, status, value_out, occupancy, input ready);
    modport sink   (input valid, status, value_out, occupancy, output ready);
endinterface

/* sv/sorted_priority_queue_core.sv */
// Channel  Dir  Interface   Payload
// -------  ---  ----------  ------------------------------------------
// req      in   spq_req_if  kind, value_in[31:0], priority_in[7:0]
// rsp      out  spq_rsp_if  status[1:0], value_out[31:0], occupancy[4:0]
//
// Each transaction is executed at the edge that accepts it: a row of 16
// compare/shift cells inserts or pops at that edge, and the result is
// registered. Throughput is one transaction per cycle while rsp is not stalled.
// req.ready stays high while a held result is being taken the same cycle;
// it drops only when rsp is stalled with a result waiting.
// rst_n (async, active low) empties the queue; entry contents are not reset.
module sorted_priority_queue_core (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    spq_pkg::cmd_t       cmd;
    spq_pkg::dp_status_t dp_status;

    // controller: handshakes, full/empty decisions, result hold
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // datapath: sorted entry array, count and result registers
    spq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value_in    (req.value_in),
        .priority_in (req.priority_in),
        .dp_status   (dp_status),
        .status      (rsp.status),
        .value_out   (rsp.value_out),
        .occupancy   (rsp.occupancy)
    );

endmodule

/* sv/spq_ctrl.sv */
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_kind,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  spq_pkg::dp_status_t dp_status,
    output spq_pkg::cmd_t       cmd
);

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // new transaction may enter while the held result is being taken
    assign req_ready = (state_reg == S_IDLE) || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = (state_reg == S_HOLD);

    always_comb
    begin
        cmd.load   = accept;
        cmd.enq    = 1'b0;
        cmd.deq    = 1'b0;
        cmd.status = spq_pkg::ST_OK;
        case (req_kind)
            spq_pkg::KIND_ENQ:
            begin
                cmd.enq = accept && !dp_status.full;
                if (dp_status.full)
                    cmd.status = spq_pkg::ST_FULL;
            end
            spq_pkg::KIND_DEQ:
            begin
                cmd.deq = accept && !dp_status.empty;
                if (dp_status.empty)
                    cmd.status = spq_pkg::ST_EMPTY;
            end
            default:
            begin
                cmd.status = spq_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (accept)
                    state_next = S_HOLD;
                else if (rsp_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/spq_datapath.sv */
module spq_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  spq_pkg::cmd_t                      cmd,
    input  logic signed [spq_pkg::VALUE_W-1:0] value_in,
    input  logic        [spq_pkg::PRIO_W-1:0]  priority_in,
    output spq_pkg::dp_status_t                dp_status,
    output logic        [spq_pkg::STAT_W-1:0]  status,
    output logic signed [spq_pkg::VALUE_W-1:0] value_out,
    output logic        [spq_pkg::CNT_W-1:0]   occupancy
);

    logic [spq_pkg::VALUE_W-1:0] val_reg [spq_pkg::DEPTH];
    logic [spq_pkg::PRIO_W-1:0]  pri_reg [spq_pkg::DEPTH];
    logic [spq_pkg::CNT_W-1:0]   count_reg;
    logic [spq_pkg::STAT_W-1:0]  status_reg;
    logic [spq_pkg::VALUE_W-1:0] value_out_reg;

    // stay[i]: entry i is held and ranks ahead of (or ties with) the new one.
    // Sorted order makes this a thermometer code from the front.
    logic [spq_pkg::DEPTH-1:0] stay;
    // prev_stay[i]: the entry in front of i stays (always true at the head)
    logic [spq_pkg::DEPTH-1:0] prev_stay;

    assign dp_status.full  = (count_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign dp_status.empty = (count_reg == '0);

    genvar gi;
    generate
        for (gi = 0; gi < spq_pkg::DEPTH; gi++)
        begin : g_cell
            assign stay[gi] = (count_reg > spq_pkg::CNT_W'(gi))
                              && (pri_reg[gi] >= priority_in);
        end
    endgenerate

    assign prev_stay = {stay[spq_pkg::DEPTH-2:0], 1'b1};

    // insert: first non-staying cell takes the new entry, cells behind it
    // shift back by one; pop: every cell but the last takes its successor
    always_ff @(posedge clk)
    begin
        if (cmd.enq)
        begin
            for (int i = 0; i < spq_pkg::DEPTH; i++)
            begin
                if (!stay[i] && prev_stay[i])
                begin
                    val_reg[i] <= value_in;
                    pri_reg[i] <= priority_in;
                end
            end
            for (int i = 1; i < spq_pkg::DEPTH; i++)
            begin
                if (!stay[i] && !prev_stay[i])
                begin
                    val_reg[i] <= val_reg[i-1];
                    pri_reg[i] <= pri_reg[i-1];
                end
            end
        end
        else if (cmd.deq)
        begin
            for (int i = 0; i < spq_pkg::DEPTH - 1; i++)
            begin
                val_reg[i] <= val_reg[i+1];
                pri_reg[i] <= pri_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.enq)
            count_reg <= count_reg + 1'b1;
        else if (cmd.deq)
            count_reg <= count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg    <= cmd.status;
            value_out_reg <= cmd.deq ? val_reg[0] : '0;
        end
    end

    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign occupancy = count_reg;

endmodule

/* sv/spq_checker.sv */
module spq_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic        [spq_pkg::STAT_W-1:0]  status,
    input logic signed [spq_pkg::VALUE_W-1:0] value_out,
    input logic        [spq_pkg::CNT_W-1:0]   occupancy
);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> occupancy <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
        else $error("occupancy above depth");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == spq_pkg::ST_FULL)
        |-> occupancy == spq_pkg::CNT_W'(spq_pkg::DEPTH))
        else $error("full reported with room left");

    a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == spq_pkg::ST_EMPTY)
        |-> (occupancy == '0 && value_out == '0))
        else $error("empty result malformed");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status)
        && $stable(value_out) && $stable(occupancy)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .value_out (rsp.value_out),
    .occupancy (rsp.occupancy)
);

/* bench/tb.sv */
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One result as the receiver sees it.
    typedef struct {
        logic [spq_pkg::STAT_W-1:0]  status;
        logic [spq_pkg::VALUE_W-1:0] value;
        logic [spq_pkg::CNT_W-1:0]   occ;
    } rsp_fields_t;

    // What the next response transaction must carry. `fixed` is a
    // hand-written answer that some directed rows add on top of the
    // shadow queue's answer.
    typedef struct {
        rsp_fields_t calc;
        bit          pinned;
        rsp_fields_t fixed;
        int          seq;
    } awaited_t;

    // One row of the directed table. A row with reps > 1 repeats the
    // operation, stepping the value by one and shuffling the priority.
    typedef struct {
        logic                        kind;
        logic [spq_pkg::VALUE_W-1:0] value;
        logic [spq_pkg::PRIO_W-1:0]  prio;
        int                          reps;
        bit                          pinned;
        logic [spq_pkg::STAT_W-1:0]  status;
        logic [spq_pkg::VALUE_W-1:0] vout;
        logic [spq_pkg::CNT_W-1:0]   occ;
    } plan_row_t;

    localparam int PLAN_ROWS = 11;
    localparam int PHASE_OPS = 560;

    logic clk;
    logic rst_n;

    spq_req_if req ();
    spq_rsp_if rsp ();

    sorted_priority_queue_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow copy of the queue, front at index 0, priorities never
    // increasing toward the back.
    logic [spq_pkg::VALUE_W-1:0] shadow_val [spq_pkg::DEPTH];
    logic [spq_pkg::PRIO_W-1:0]  shadow_pri [spq_pkg::DEPTH];
    int                          shadow_cnt;

    awaited_t awaited_rsp [$];
    int       sent_count;
    int       err_count;

    // Idle rates in percent, changed per phase.
    int send_idle;
    int rcv_idle;

    plan_row_t plan [PLAN_ROWS] = '{
        // dequeue right after reset: empty, nothing held
        '{spq_pkg::KIND_DEQ, 32'h0000_0000, 8'h00,  1, 1'b1, spq_pkg::ST_EMPTY,
          32'h0000_0000, 5'd0},
        // value and priority extremes, plus a tie at the top priority
        '{spq_pkg::KIND_ENQ, 32'h7FFF_FFFF, 8'h00,  1, 1'b1, spq_pkg::ST_OK,
          32'h0000_0000, 5'd1},
        '{spq_pkg::KIND_ENQ, 32'h8000_0000, 8'hFF,  1, 1'b1, spq_pkg::ST_OK,
          32'h0000_0000, 5'd2},
        '{spq_pkg::KIND_ENQ, 32'hFFFF_FFFF, 8'hFF,  1, 1'b1, spq_pkg::ST_OK,
          32'h0000_0000, 5'd3},
        // equal priorities leave in arrival order
        '{spq_pkg::KIND_DEQ, 32'h0000_0000, 8'h00,  1, 1'b1, spq_pkg::ST_OK,
          32'h8000_0000, 5'd2},
        '{spq_pkg::KIND_DEQ, 32'h0000_0000, 8'h00,  1, 1'b1, spq_pkg::ST_OK,
          32'hFFFF_FFFF, 5'd1},
        '{spq_pkg::KIND_DEQ, 32'h0000_0000, 8'h00,  1, 1'b1, spq_pkg::ST_OK,
          32'h7FFF_FFFF, 5'd0},
        '{spq_pkg::KIND_DEQ, 32'h0000_0000, 8'h00,  1, 1'b1, spq_pkg::ST_EMPTY,
          32'h0000_0000, 5'd0},
        // fill to the brim with mixed priorities and ties
        '{spq_pkg::KIND_ENQ, 32'hA5A5_0000, 8'h11, 16, 1'b0, spq_pkg::ST_OK,
          32'h0000_0000, 5'd0},
        // enqueue on a full queue is turned away
        '{spq_pkg::KIND_ENQ, 32'h5A5A_5A5A, 8'hFF,  1, 1'b1, spq_pkg::ST_FULL,
          32'h0000_0000, 5'd16},
        // dequeue from a full queue
        '{spq_pkg::KIND_DEQ, 32'h0000_0000, 8'h00,  1, 1'b0, spq_pkg::ST_OK,
          32'h0000_0000, 5'd0}
    };

    // Apply one transaction to the shadow queue and return its result.
    function automatic rsp_fields_t shadow_apply(logic kind,
                                                 logic [spq_pkg::VALUE_W-1:0] value,
                                                 logic [spq_pkg::PRIO_W-1:0] prio);
        rsp_fields_t r;
        int          pos;
        r.status = spq_pkg::ST_OK;
        r.value  = '0;
        if (kind == spq_pkg::KIND_ENQ) begin
            if (shadow_cnt >= spq_pkg::DEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end
            else begin
                // behind every entry of higher or equal priority
                pos = 0;
                while (pos < shadow_cnt && shadow_pri[pos] >= prio)
                    pos++;
                for (int k = shadow_cnt; k > pos; k--)
                begin
                    shadow_val[k] = shadow_val[k-1];
                    shadow_pri[k] = shadow_pri[k-1];
                end
                shadow_val[pos] = value;
                shadow_pri[pos] = prio;
                shadow_cnt++;
            end
        end
        else begin
            if (shadow_cnt == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end
            else begin
                r.value = shadow_val[0];
                for (int k = 1; k < shadow_cnt; k++)
                begin
                    shadow_val[k-1] = shadow_val[k];
                    shadow_pri[k-1] = shadow_pri[k];
                end
                shadow_cnt--;
            end
        end
        r.occ = spq_pkg::CNT_W'(shadow_cnt);
        return r;
    endfunction

    task automatic report_mismatch(int seq, string field, logic [31:0] got,
                                   logic [31:0] want);
        err_count++;
        $display("[%0t] txn %0d %s: got %h want %h", $realtime, seq, field, got, want);
    endtask

    task automatic compare_rsp(int seq, string tag, rsp_fields_t got, rsp_fields_t want);
        if (got.status !== want.status)
            report_mismatch(seq, {tag, " status"}, 32'(got.status), 32'(want.status));
        if (got.value !== want.value)
            report_mismatch(seq, {tag, " value_out"}, got.value, want.value);
        if (got.occ !== want.occ)
            report_mismatch(seq, {tag, " occupancy"}, 32'(got.occ), 32'(want.occ));
    endtask

    // Offer one request transaction, with a random number of idle cycles
    // in front, and predict its result once it is taken.
    task automatic send_op(logic kind, logic [spq_pkg::VALUE_W-1:0] value,
                           logic [spq_pkg::PRIO_W-1:0] prio,
                           bit pinned, rsp_fields_t fixed);
        awaited_t a;
        while ($urandom_range(99) < send_idle)
        begin
            // junk on the payload while valid is low
            req.valid       <= 1'b0;
            req.kind        <= 1'($urandom);
            req.value_in    <= $urandom;
            req.priority_in <= spq_pkg::PRIO_W'($urandom);
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.kind        <= kind;
        req.value_in    <= value;
        req.priority_in <= prio;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        a.calc   = shadow_apply(kind, value, prio);
        a.pinned = pinned;
        a.fixed  = fixed;
        a.seq    = sent_count;
        sent_count++;
        awaited_rsp.push_back(a);
    endtask

    // Hold off the sender until every result is back.
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    always #1 clk = ~clk;

    // Receiver: random backpressure at the current rate.
    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= rcv_idle);

    // Response checker: every taken result against the oldest prediction.
    always @(posedge clk)
    begin
        rsp_fields_t got;
        awaited_t    a;
        if (rst_n && rsp.valid && rsp.ready) begin
            got.status = rsp.status;
            got.value  = rsp.value_out;
            got.occ    = rsp.occupancy;
            if (awaited_rsp.size() == 0) begin
                report_mismatch(-1, "unexpected result", got.value, 32'h0);
            end
            else begin
                a = awaited_rsp.pop_front();
                compare_rsp(a.seq, "predicted", got, a.calc);
                if (a.pinned)
                    compare_rsp(a.seq, "fixed", got, a.fixed);
            end
        end
    end

    // Stimulus: directed table, then three random phases with different
    // idling on each side.
    initial
    begin
        rsp_fields_t                 fixed;
        rsp_fields_t                 none;
        logic                        kind;
        logic [spq_pkg::VALUE_W-1:0] value;
        logic [spq_pkg::PRIO_W-1:0]  prio;
        int                          enq_bias;
        int                          prio_mode;

        none            = '{default: '0};
        clk             = 1'b0;
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.kind        = spq_pkg::KIND_ENQ;
        req.value_in    = '0;
        req.priority_in = '0;
        rsp.ready       = 1'b0;
        shadow_cnt      = 0;
        sent_count      = 0;
        err_count       = 0;
        enq_bias        = 50;
        send_idle       = 33;
        rcv_idle        = 58;
        foreach (shadow_val[i])
        begin
            shadow_val[i] = '0;
            shadow_pri[i] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            fixed.status = plan[r].status;
            fixed.value  = plan[r].vout;
            fixed.occ    = plan[r].occ;
            for (int n = 0; n < plan[r].reps; n++)
                send_op(plan[r].kind, plan[r].value + spq_pkg::VALUE_W'(n),
                        plan[r].prio + spq_pkg::PRIO_W'(n % 5) * 8'h3B,
                        plan[r].pinned, fixed);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin send_idle = 33; rcv_idle = 58; end
                1: begin send_idle = 58; rcv_idle = 33; end
                default: begin send_idle = 0; rcv_idle = 0; end
            endcase
            prio_mode = 0;
            for (int i = 0; i < PHASE_OPS; i++)
            begin
                // Segments lean toward filling or emptying so that both
                // the full and the empty edge get hit again and again.
                if (i % 40 == 0) begin
                    case ($urandom_range(3))
                        0: enq_bias = 15;
                        1: enq_bias = 50;
                        2: enq_bias = 70;
                        default: enq_bias = 92;
                    endcase
                    prio_mode = $urandom_range(3);
                end
                kind = ($urandom_range(99) < enq_bias) ? spq_pkg::KIND_ENQ
                                                       : spq_pkg::KIND_DEQ;
                case (prio_mode)
                    0: prio = spq_pkg::PRIO_W'($urandom);
                    1: prio = spq_pkg::PRIO_W'($urandom_range(3));
                    2: prio = $urandom_range(1) ? 8'hFF : 8'h00;
                    default: prio = spq_pkg::PRIO_W'($urandom_range(255, 250));
                endcase
                case ($urandom_range(15))
                    0: value = 32'h8000_0000;
                    1: value = 32'h7FFF_FFFF;
                    2: value = 32'hFFFF_FFFF;
                    3: value = 32'h0000_0000;
                    default: value = $urandom;
                endcase
                send_op(kind, value, prio, 1'b0, none);
            end
            drain();
        end

        // Quiet tail: catch any stray result after the last one.
        rcv_idle = 0;
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
